FILE: sv/wcel_pkg.sv
// Package for the weighted cross-entropy loss block.
// Holds the transfer payload types, register indices, states and constants.
// No dependencies.
package wcel_pkg;

   localparam int NUM_CLASSES = 64;
   localparam int CLASS_W     = $clog2(NUM_CLASSES);

   localparam logic [15:0] PROB_ONE   = 16'd32768;
   localparam logic [15:0] WEIGHT_ONE = 16'd256;
   localparam logic [31:0] LN2_Q32    = 32'd2977044472;
   localparam logic [47:0] LOSS_MAX   = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      CSR_IGNORE_ENABLE = 3'd0,
      CSR_IGNORE_VALUE  = 3'd1,
      CSR_NORM_MODE     = 3'd2,
      CSR_OUTER_COUNT   = 3'd3,
      CSR_INNER_COUNT   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      NORM_FULL  = 2'd0,
      NORM_VALID = 2'd1,
      NORM_BATCH = 2'd2,
      NORM_NONE  = 2'd3
   } norm_mode_type;

   typedef enum logic {
      FUNC_WEIGHT = 1'b0,
      FUNC_SCORE  = 1'b1
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOG,
      ST_SQR,
      ST_LN,
      ST_WMUL,
      ST_ACC,
      ST_NORM,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        func;
      logic [7:0]  class_label;
      logic [15:0] prob;
      logic [15:0] weight_value;
      logic        last;
   } wcel_req_type;

   typedef struct packed {
      logic [47:0] loss;
      logic [31:0] pos_count;
      logic        label_error;
   } wcel_rsp_type;

endpackage

FILE: sv/weighted_cross_entropy_loss_top.sv
// Weighted cross-entropy loss block: top level and only module.
// Depends on wcel_pkg for payload types, register indices, states and constants.
//
// Usage: each req_ transfer either loads one class weight (func 0) or scores one
// labelled position (func 1). A scoring transfer with a label in range and not
// ignored adds weight times -ln(prob) to the accumulator; one marked last also
// divides by the chosen normaliser and offers one result on the rsp_ channel,
// then clears the accumulator and count. A weight load leaves the block idle.
// A scored position forms the log by 16 repeated squarings on one shared 32x32
// multiplier, which also serves the ln2 scaling, the weight product and the
// normaliser. A last item adds bit-serial 64 by 32 bit division and rounding.
// req_ready is high only while the block is idle. A finished result is held in
// an output register, so the next items are accepted while it waits; a further
// result waits until the previous one has been taken. The csr_ port must be
// used only while the block is idle; the block does not enforce this.
// Synchronous reset clears the accumulator, count and error flag, sets the
// registers to their defaults and marks all class weights as 1.0.
module weighted_cross_entropy_loss_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wcel_pkg::wcel_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output wcel_pkg::wcel_rsp_type rsp_data,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [15:0]           csr_wdata
);
   import wcel_pkg::*;

   state_type     state_ff, state_in;
   logic          ign_en_ff;
   logic [7:0]    ign_val_ff;
   logic [1:0]    norm_mode_ff;
   logic [15:0]   outer_ff;
   logic [15:0]   inner_ff;

   logic [63:0]   loss_ff, loss_in;
   logic [31:0]   count_ff, count_in;
   logic          err_ff, err_in;
   logic          last_ff, last_in;
   logic [15:0]   prob_ff, prob_in;
   logic [31:0]   m_ff, m_in;
   logic [3:0]    e_ff, e_in;
   logic [15:0]   frac_ff, frac_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [31:0]   den_ff, den_in;
   logic [31:0]   rem_ff, rem_in;
   logic [63:0]   quo_ff, quo_in;
   logic          rsp_valid_ff, rsp_valid_in;
   wcel_rsp_type  rsp_ff, rsp_in;

   logic [15:0]   wmem [NUM_CLASSES];
   logic [NUM_CLASSES-1:0] wvld_ff;
   logic [15:0]   wrd_ff;
   logic          wrd_vld_ff;
   logic [15:0]   weight;

   logic          req_fire;
   logic          label_in_range;
   logic [31:0]   mul_a, mul_b;
   logic [63:0]   mul_p;
   logic [15:0]   p_clamp;
   logic [3:0]    e_calc;
   logic [31:0]   sq;
   logic [19:0]   n2;
   logic [64:0]   sum;
   logic [32:0]   rem_sh;
   logic [31:0]   norm_sel;
   logic [64:0]   q_rnd;

   assign req_ready      = (state_ff == ST_IDLE);
   assign req_fire       = req_valid && req_ready;
   assign label_in_range = ({1'b0, req_data.class_label} < 9'(NUM_CLASSES));
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_ff;
   assign weight         = wrd_vld_ff ? wrd_ff : WEIGHT_ONE;
   assign mul_p          = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         ign_en_ff    <= 1'b0;
         ign_val_ff   <= 8'd255;
         norm_mode_ff <= NORM_VALID;
         outer_ff     <= 16'd1;
         inner_ff     <= 16'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IGNORE_ENABLE: ign_en_ff    <= csr_wdata[0];
            CSR_IGNORE_VALUE:  ign_val_ff   <= csr_wdata[7:0];
            CSR_NORM_MODE:     norm_mode_ff <= csr_wdata[1:0];
            CSR_OUTER_COUNT:   outer_ff     <= csr_wdata;
            CSR_INNER_COUNT:   inner_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_data.func == FUNC_WEIGHT && label_in_range) begin
         wmem[req_data.class_label[CLASS_W-1:0]] <= req_data.weight_value;
      end
      if (req_fire) begin
         wrd_ff     <= wmem[req_data.class_label[CLASS_W-1:0]];
         wrd_vld_ff <= wvld_ff[req_data.class_label[CLASS_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wvld_ff <= '0;
      end else if (req_fire && req_data.func == FUNC_WEIGHT && label_in_range) begin
         wvld_ff[req_data.class_label[CLASS_W-1:0]] <= 1'b1;
      end
   end

   always_comb begin
      p_clamp = (prob_ff == 16'd0) ? 16'd1 : ((prob_ff > PROB_ONE) ? PROB_ONE : prob_ff);
      e_calc  = 4'd0;
      for (int i = 1; i < 16; i++) begin
         if (p_clamp[i]) begin
            e_calc = 4'(i);
         end
      end
   end

   always_comb begin
      unique case (norm_mode_ff)
         NORM_FULL:  norm_sel = mul_p[31:0];
         NORM_VALID: norm_sel = count_ff;
         NORM_BATCH: norm_sel = {16'd0, outer_ff};
         NORM_NONE:  norm_sel = 32'd1;
         default:    norm_sel = 32'd1;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      loss_in      = loss_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      last_in      = last_ff;
      prob_in      = prob_ff;
      m_in         = m_ff;
      e_in         = e_ff;
      frac_in      = frac_ff;
      cnt_in       = cnt_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mul_a        = m_ff;
      mul_b        = m_ff;
      sq           = mul_p[61:30];
      n2           = 20'(15 << 16) - {e_ff, frac_ff};
      sum          = {1'b0, loss_ff} + {33'd0, m_ff};
      rem_sh       = {rem_ff, quo_ff[63]};
      q_rnd        = {1'b0, quo_ff} + {64'd0, ({rem_ff, 1'b0} >= {1'b0, den_ff})};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_data.func == FUNC_SCORE) begin
               last_in = req_data.last;
               prob_in = req_data.prob;
               if (ign_en_ff && req_data.class_label == ign_val_ff) begin
                  state_in = req_data.last ? ST_NORM : ST_IDLE;
               end else if (!label_in_range) begin
                  err_in   = 1'b1;
                  state_in = req_data.last ? ST_NORM : ST_IDLE;
               end else begin
                  state_in = ST_LOG;
               end
            end
         end
         ST_LOG: begin
            e_in     = e_calc;
            m_in     = {16'd0, p_clamp} << (5'd30 - {1'b0, e_calc});
            frac_in  = '0;
            cnt_in   = '0;
            state_in = ST_SQR;
         end
         ST_SQR: begin
            frac_in = {frac_ff[14:0], sq[31]};
            m_in    = sq[31] ? {1'b0, sq[31:1]} : sq;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff[3:0] == 4'd15) begin
               state_in = ST_LN;
            end
         end
         ST_LN: begin
            mul_a    = {12'd0, n2};
            mul_b    = LN2_Q32;
            m_in     = 32'((mul_p + 64'h8000_0000) >> 32);
            state_in = ST_WMUL;
         end
         ST_WMUL: begin
            mul_a    = {16'd0, weight};
            mul_b    = m_ff;
            m_in     = 32'((mul_p + 64'd128) >> 8);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            loss_in  = sum[64] ? '1 : sum[63:0];
            count_in = (count_ff == '1) ? count_ff : count_ff + 32'd1;
            state_in = last_ff ? ST_NORM : ST_IDLE;
         end
         ST_NORM: begin
            mul_a    = {16'd0, outer_ff};
            mul_b    = {16'd0, inner_ff};
            den_in   = (norm_sel == 32'd0) ? 32'd1 : norm_sel;
            rem_in   = '0;
            quo_in   = loss_ff;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = 32'(rem_sh - {1'b0, den_ff});
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = rem_sh[31:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.loss       = (q_rnd > {17'd0, LOSS_MAX}) ? LOSS_MAX : q_rnd[47:0];
               rsp_in.pos_count  = count_ff;
               rsp_in.label_error = err_ff;
               loss_in           = '0;
               count_in          = '0;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loss_ff      <= '0;
         count_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         loss_ff      <= loss_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      prob_ff <= prob_in;
      m_ff    <= m_in;
      e_ff    <= e_in;
      frac_ff <= frac_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      rsp_ff  <= rsp_in;
   end

endmodule
